### design/ple_pkg.sv
// Shared types and codes for the positional list engine.
// No dependencies; ple_seq and positional_list_engine_core import this package.
`default_nettype none

package ple_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam logic [2:0] FN_INSERT = 3'd0;
    localparam logic [2:0] FN_REMOVE = 3'd1;
    localparam logic [2:0] FN_GET    = 3'd2;
    localparam logic [2:0] FN_SET    = 3'd3;
    localparam logic [2:0] FN_CLEAR  = 3'd4;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [2:0]         func;
        logic [6:0]         position;
        logic signed [31:0] value;
    } ple_req_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
        logic [6:0]         count;
        logic               is_empty;
    } ple_rsp_t;

    // Handshake between the sequencer and the top-level output register.
    typedef struct packed {
        logic ready;
        logic done;
    } ple_seq_stat_t;

endpackage

`default_nettype wire

### design/ple_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### design/ple_seq.sv
// Sequencer of the positional list engine: holds the entry count and steps a
// shared address unit through the entry RAM to move entries one per cycle.
// Depends on ple_pkg; drives the ports of one ple_ram instance.
`default_nettype none

module ple_seq #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire ple_pkg::ple_req_t           req,
    input  wire logic                        take,
    output ple_pkg::ple_seq_stat_t           stat,
    output ple_pkg::ple_rsp_t                res,
    output logic                             mem_we,
    output logic [$clog2(CAPACITY)-1:0]      mem_waddr,
    output logic [31:0]                      mem_wdata,
    output logic [$clog2(CAPACITY)-1:0]      mem_raddr,
    input  wire logic [31:0]                 mem_rdata
);

    import ple_pkg::*;

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 7) ? CW : 7;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_INSW  = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              up_reg, up_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     rd_addr_reg, rd_addr_next;
    logic [AW-1:0]     wr_addr_reg, wr_addr_next;
    logic [AW-1:0]     last_reg, last_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic [31:0]       val_reg, val_next;
    logic [31:0]       rd_reg, rd_next;
    logic [1:0]        status_reg, status_next;

    logic [CMPW-1:0]   pos_w;
    logic [CMPW-1:0]   count_w;
    logic [AW-1:0]     pos_a;
    logic [AW-1:0]     cnt_m1_a;
    logic [AW-1:0]     step_addr;

    assign pos_w    = CMPW'(req.position);
    assign count_w  = CMPW'(count_reg);
    assign pos_a    = pos_w[AW-1:0];
    assign cnt_m1_a = AW'(count_reg - 1'b1);

    // Shared address unit: one step toward the end of the move.
    assign step_addr = up_reg ? AW'(rd_addr_reg - 1'b1) : AW'(rd_addr_reg + 1'b1);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        up_next      = up_reg;
        pend_next    = pend_reg;
        rd_addr_next = rd_addr_reg;
        wr_addr_next = wr_addr_reg;
        last_next    = last_reg;
        pos_next     = pos_reg;
        val_next     = val_reg;
        rd_next      = rd_reg;
        status_next  = status_reg;
        mem_we       = 1'b0;
        mem_waddr    = wr_addr_reg;
        mem_wdata    = mem_rdata;
        mem_raddr    = rd_addr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                mem_raddr = pos_a;
                if (start)
                begin
                    rd_next     = '0;
                    status_next = ST_DONE;
                    pos_next    = pos_a;
                    val_next    = req.value;
                    state_next  = S_FIN;
                    case (req.func)
                        FN_INSERT:
                        begin
                            if (pos_w > count_w)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else if (count_w >= CMPW'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                            end
                            else if (pos_w == count_w)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = pos_a;
                                mem_wdata  = req.value;
                                count_next = CW'(count_reg + 1'b1);
                            end
                            else
                            begin
                                up_next      = 1'b1;
                                pend_next    = 1'b0;
                                rd_addr_next = cnt_m1_a;
                                last_next    = pos_a;
                                state_next   = S_SHIFT;
                            end
                        end
                        FN_REMOVE:
                        begin
                            if (pos_w >= count_w)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else if (pos_a == cnt_m1_a)
                            begin
                                count_next = CW'(count_reg - 1'b1);
                            end
                            else
                            begin
                                up_next      = 1'b0;
                                pend_next    = 1'b0;
                                rd_addr_next = AW'(pos_a + 1'b1);
                                last_next    = cnt_m1_a;
                                state_next   = S_SHIFT;
                            end
                        end
                        FN_GET:
                        begin
                            if (pos_w >= count_w)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        FN_SET:
                        begin
                            if (pos_w >= count_w)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = pos_a;
                                mem_wdata = req.value;
                            end
                        end
                        FN_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                rd_next    = mem_rdata;
                state_next = S_FIN;
            end
            S_SHIFT:
            begin
                // The entry read last cycle lands one place over while the next is read.
                mem_we       = pend_reg;
                pend_next    = 1'b1;
                wr_addr_next = up_reg ? AW'(rd_addr_reg + 1'b1) : AW'(rd_addr_reg - 1'b1);
                rd_addr_next = step_addr;
                if (rd_addr_reg == last_reg)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                mem_we = 1'b1;
                if (up_reg)
                begin
                    state_next = S_INSW;
                end
                else
                begin
                    count_next = CW'(count_reg - 1'b1);
                    state_next = S_FIN;
                end
            end
            S_INSW:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = val_reg;
                count_next = CW'(count_reg + 1'b1);
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        up_reg      <= up_next;
        rd_addr_reg <= rd_addr_next;
        wr_addr_reg <= wr_addr_next;
        last_reg    <= last_next;
        pos_reg     <= pos_next;
        val_reg     <= val_next;
        rd_reg      <= rd_next;
        status_reg  <= status_next;
    end

    assign stat.ready     = (state_reg == S_IDLE);
    assign stat.done      = (state_reg == S_FIN);
    assign res.read_value = rd_reg;
    assign res.status     = status_reg;
    assign res.count      = 7'(count_reg);
    assign res.is_empty   = (count_reg == '0);

endmodule

`default_nettype wire

### design/positional_list_engine_core.sv
// Top level of the positional list engine: request/response handshakes and the
// output register. Depends on ple_pkg, ple_seq and ple_ram.
//
//  Channel   Direction  Handshake              Payload
//  req       in         req_valid/req_ready    ple_req_t (func, position, value)
//  rsp       out        rsp_valid/rsp_ready    ple_rsp_t (read_value, status, count, is_empty)
//
// One request is worked at a time; req_ready is high only while the sequencer idles.
// Insert and remove in the middle shift the entries behind the position one place over:
// the entry RAM moves one entry per cycle through its ports.
// The output register lets a new request enter while a response waits on rsp_ready.
// Reset clears the count and all handshake state; no clearing pass is needed.
`default_nettype none

module positional_list_engine_core #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire ple_pkg::ple_req_t req,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output ple_pkg::ple_rsp_t      rsp
);

    import ple_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    ple_seq_stat_t stat;
    ple_rsp_t      res;
    logic          take;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [31:0]   mem_wdata;
    logic [31:0]   mem_rdata;
    logic          rsp_valid_reg;
    ple_rsp_t      rsp_reg;

    assign req_ready = stat.ready;
    assign take      = stat.done && (!rsp_valid_reg || rsp_ready);

    ple_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (req_valid && req_ready),
        .req       (req),
        .take      (take),
        .stat      (stat),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    ple_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("sequencer still ready after accepting a transaction");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.done && !take) |=> (stat.done && $stable(res)))
        else $error("finished result changed before hand-off");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.is_empty) |-> (rsp.count == 7'd0))
        else $error("empty flag set with a nonzero count");

    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != ST_DONE) |-> (rsp.read_value == 32'sd0))
        else $error("nonzero read value on a failed transaction");

endmodule

`default_nettype wire
